>>> hdl/ascii_decimal_integer_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII decimal integer parser
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH
`define ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication.
`define ADIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/adip_pkg.sv
// ----------------------------------------------------------------------------
// adip_pkg
// Types and constants shared by the ASCII decimal integer parser.
// ----------------------------------------------------------------------------
package adip_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int OUT_WIDTH       = 64;
    localparam int BYTE_WIDTH      = 8;

    localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'd45;
    localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'd48;
    localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'd57;

    typedef enum logic [2:0] {
        PH_SEEK = 3'b001,
        PH_SIGN = 3'b010,
        PH_NUM  = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   negative;
        logic   overflowed;
    } t_num_ctl;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 overflow;
    } t_result;

endpackage

>>> hdl/adip_step.sv
// ----------------------------------------------------------------------------
// adip_step
// Per-byte update of the number state: parse phase, magnitude and flags.
// ----------------------------------------------------------------------------
module adip_step #(
    parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
) (
    input  logic [adip_pkg::BYTE_WIDTH-1:0] i_byte,
    input  logic                            i_signed_mode,
    input  adip_pkg::t_num_ctl              i_ctl,
    input  logic [VALUE_WIDTH-1:0]          i_mag,
    output adip_pkg::t_num_ctl              o_ctl,
    output logic [VALUE_WIDTH-1:0]          o_mag,
    output logic                            o_emit,
    output adip_pkg::t_result               o_result
);
    import adip_pkg::*;

    localparam int FW = VALUE_WIDTH + 4;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [FW-1:0]          full;
    logic [VALUE_WIDTH-1:0] lim;
    logic                   over;
    logic [VALUE_WIDTH-1:0] signed_val;

    assign is_digit = i_byte inside {[CH_ZERO:CH_NINE]};
    assign digit    = i_byte[3:0];

    // mag*10 + d, exact in four extra bits
    assign full = {1'b0, i_mag, 3'b000} + {3'b000, i_mag, 1'b0}
                + {{VALUE_WIDTH{1'b0}}, digit};

    always_comb begin
        if (i_ctl.negative) begin
            lim = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else if (i_signed_mode) begin
            lim = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else begin
            lim = '1;
        end
    end

    assign over       = full > {4'b0000, lim};
    assign signed_val = i_ctl.negative ? ({VALUE_WIDTH{1'b0}} - i_mag) : i_mag;

    assign o_result.value    = OUT_WIDTH'(signed_val);
    assign o_result.overflow = i_ctl.overflowed;

    always_comb begin
        o_ctl  = i_ctl;
        o_mag  = i_mag;
        o_emit = 1'b0;
        case (i_ctl.phase)
            PH_SIGN: begin
                // take the low nibble unchecked as first digit
                o_mag            = VALUE_WIDTH'(digit);
                o_ctl.negative   = 1'b1;
                o_ctl.overflowed = 1'b0;
                o_ctl.phase      = PH_NUM;
            end
            PH_NUM: begin
                if (is_digit) begin
                    o_mag = full[VALUE_WIDTH-1:0];
                    if (over) begin
                        o_ctl.overflowed = 1'b1;
                    end
                end else begin
                    o_emit = 1'b1;
                    o_mag  = '0;
                    o_ctl  = '{phase: PH_SEEK, negative: 1'b0, overflowed: 1'b0};
                end
            end
            default: begin
                o_ctl.phase = PH_SEEK;
                if (is_digit) begin
                    o_mag = VALUE_WIDTH'(digit);
                    o_ctl = '{phase: PH_NUM, negative: 1'b0, overflowed: 1'b0};
                end else if (i_byte == CH_MINUS && i_signed_mode) begin
                    o_ctl.phase = PH_SIGN;
                end
            end
        endcase
    end

endmodule

>>> hdl/adip_out_reg.sv
// ----------------------------------------------------------------------------
// adip_out_reg
// Result register on the output channel; holds a transaction while stalled.
// ----------------------------------------------------------------------------
module adip_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  adip_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output adip_pkg::t_result o_result
);
    import adip_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_ready  = !r_vld || !i_stall;
    assign o_valid  = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

endmodule

>>> hdl/ascii_decimal_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_decimal_integer_parser
// Streams ASCII bytes and emits each decimal integer found as a binary value.
// ----------------------------------------------------------------------------
// One byte per cycle while the output is not stalled: a byte is taken into
// the input register, then one step of shift-add logic (magnitude*10 +
// digit and the range compare) updates the number state. A byte that ends a
// number loads the result register, which can hold a transaction while the
// output is stalled; the input register keeps taking bytes until both
// registers are full and the output is stalled. Numbers are tracked as a
// magnitude and a sign flag; the value is negated on its way into the result
// register. Non-digit bytes are skipped while seeking; in signed mode a
// minus makes the next byte's low nibble the first digit. The terminating
// byte is consumed, never examined as a sign. The overflow bit marks any
// number that left the signed or unsigned range and wrapped modulo
// 2^VALUE_WIDTH; bits of o_out_value above VALUE_WIDTH are zero. Write
// signed_mode only while the block is idle.
// ----------------------------------------------------------------------------
`include "ascii_decimal_integer_parser_assert.svh"

module ascii_decimal_integer_parser #(
    parameter int VALUE_WIDTH = adip_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    // input byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [adip_pkg::BYTE_WIDTH-1:0] i_in_byte,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [adip_pkg::OUT_WIDTH-1:0]  o_out_value,
    output logic                            o_out_overflow
);
    import adip_pkg::*;

    // input register
    logic                   r_in_vld;
    logic [BYTE_WIDTH-1:0]  r_in_byte;

    // number state
    logic                   r_signed_mode;
    t_num_ctl               r_ctl;
    t_num_ctl               n_ctl;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;

    logic                   emit;
    t_result                step_res;
    t_result                out_res;
    logic                   out_ready;
    logic                   adv;
    logic                   load;

    // Advance the state only when a finished result has somewhere to go.
    assign adv        = r_in_vld && out_ready;
    assign load       = adv && emit;
    assign o_in_stall = r_in_vld && !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    // Accept a new byte whenever the held one moves on (or none is held).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{phase: PH_SEEK, negative: 1'b0, overflowed: 1'b0};
            r_mag <= '0;
        end else if (adv) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

    adip_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_byte        (r_in_byte),
        .i_signed_mode (r_signed_mode),
        .i_ctl         (r_ctl),
        .i_mag         (r_mag),
        .o_ctl         (n_ctl),
        .o_mag         (n_mag),
        .o_emit        (emit),
        .o_result      (step_res)
    );

    adip_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (step_res),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    assign o_out_value    = out_res.value;
    assign o_out_overflow = out_res.overflow;

    // A finished number always shows up on the output next cycle.
    `ADIP_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, load, o_out_valid,
        "result load did not raise output valid")
    // A terminated number leaves the state cleared for the next one.
    `ADIP_ASSERT_NEXT(a_emit_clears, i_clk, i_rst_n, load,
        r_ctl.phase == PH_SEEK && r_mag == '0 && !r_ctl.overflowed,
        "number state not cleared after emit")
    // A held byte blocked by the output must not move the number state.
    `ADIP_ASSERT_NEXT(a_blocked_holds, i_clk, i_rst_n, r_in_vld && !out_ready,
        $stable(r_mag) && $stable(r_ctl),
        "number state moved while blocked")
    // Only a number in progress can carry the overflow flag.
    `ADIP_ASSERT_NOW(a_ovf_in_num, i_clk, i_rst_n, r_ctl.overflowed,
        r_ctl.phase == PH_NUM,
        "overflow flag set outside a number")

endmodule
